>>> rtl/hcl_pkg.sv
// Shared types and character/result codes for the hex command line tokenizer.
`timescale 1ns / 1ps
package hcl_pkg;

	localparam int TAG_W  = 3;
	localparam int VAL_W  = 8;
	localparam int CMD_W  = 3;
	localparam int KIND_W = 2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ENTRY    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COMMAND  = 2'd2;

	// entry tags
	localparam logic [TAG_W-1:0] TAG_DATA   = 3'd0;
	localparam logic [TAG_W-1:0] TAG_ADDR   = 3'd1;
	localparam logic [TAG_W-1:0] TAG_WRITE  = 3'd2;
	localparam logic [TAG_W-1:0] TAG_READ   = 3'd3;
	localparam logic [TAG_W-1:0] TAG_COUNT  = 3'd4;
	localparam logic [TAG_W-1:0] TAG_BCOUNT = 3'd5;
	localparam logic [TAG_W-1:0] TAG_PCALL  = 3'd6;
	localparam logic [TAG_W-1:0] TAG_STOP   = 3'd7;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SCAN     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_STATUS   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEC_SET  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_IDENTIFY = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SPD100   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SPD400   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPD10    = 3'd6;
	localparam logic [CMD_W-1:0] CMD_BUS_RST  = 3'd7;

	// ASCII codes
	localparam logic [7:0] CH_NL       = 8'h0A;
	localparam logic [7:0] CH_BANG     = 8'h21;
	localparam logic [7:0] CH_HASH     = 8'h23;
	localparam logic [7:0] CH_DOLLAR   = 8'h24;
	localparam logic [7:0] CH_AMP      = 8'h26;
	localparam logic [7:0] CH_0        = 8'h30;
	localparam logic [7:0] CH_9        = 8'h39;
	localparam logic [7:0] CH_EQ       = 8'h3D;
	localparam logic [7:0] CH_QUEST    = 8'h3F;
	localparam logic [7:0] CH_AT       = 8'h40;
	localparam logic [7:0] CH_A        = 8'h41;
	localparam logic [7:0] CH_F        = 8'h46;
	localparam logic [7:0] CH_I        = 8'h49;
	localparam logic [7:0] CH_P        = 8'h50;
	localparam logic [7:0] CH_R        = 8'h52;
	localparam logic [7:0] CH_S        = 8'h53;
	localparam logic [7:0] CH_T        = 8'h54;
	localparam logic [7:0] CH_V        = 8'h56;
	localparam logic [7:0] CH_W        = 8'h57;
	localparam logic [7:0] CH_X        = 8'h58;
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'd32;
	localparam logic [7:0] ALPHA_BIAS  = 8'd55;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMD,
		S_DRAIN_RD,
		S_DRAIN_WR,
		S_STOP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;      // input transfer this cycle
		logic load_cmd;    // emit the pending command event
		logic load_entry;  // emit the line entry at the read pointer
		logic load_stop;   // emit the stop entry
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;     // output register can take a result this cycle
		logic ovf;          // line buffer full for the byte on the input
		logic is_cmd;       // byte on the input is a command character
		logic start_drain;  // byte on the input is a newline ending a frame
		logic rd_last;      // read pointer sits on the final entry
	} dp_status_t;

endpackage

>>> rtl/hcl_ctrl.sv
// Control state machine of the hex command line tokenizer.
`timescale 1ns / 1ps
module hcl_ctrl
	import hcl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid && status.out_free) begin
					if (status.ovf && status.is_cmd) begin
						state_d = S_CMD;
					end else if (status.start_drain) begin
						state_d = S_DRAIN_RD;
					end
				end
			end
			S_CMD: begin
				if (status.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_DRAIN_RD: begin
				state_d = S_DRAIN_WR;
			end
			S_DRAIN_WR: begin
				if (status.out_free) begin
					state_d = status.rd_last ? S_STOP : S_DRAIN_RD;
				end
			end
			S_STOP: begin
				if (status.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				s_tready   = status.out_free;
				cmd.accept = s_tvalid && status.out_free;
			end
			S_CMD: begin
				cmd.load_cmd = status.out_free;
			end
			S_DRAIN_RD: begin
			end
			S_DRAIN_WR: begin
				cmd.load_entry = status.out_free;
			end
			S_STOP: begin
				cmd.load_stop = status.out_free;
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_ready_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready)
		else $error("input ready outside idle");

	a_last_entry_to_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN_WR && status.out_free && status.rd_last) |=> (state_q == S_STOP))
		else $error("drain did not close with a stop entry");

	a_ovf_no_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && status.ovf) |-> !status.start_drain)
		else $error("drain started on an overflowed line");
`endif

endmodule

>>> rtl/hcl_dp.sv
// Datapath of the hex command line tokenizer: decode, line state, line buffer, output register.
`timescale 1ns / 1ps
module hcl_dp
	import hcl_pkg::*;
#(
	parameter int LINE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   cmd,
	output dp_status_t  status,
	input  logic [7:0]  s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	localparam int IW = $clog2(LINE_DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(LINE_DEPTH - 1);

	// line state
	logic [VAL_W-1:0] acc_q;
	logic [IW-1:0]    idx_q;
	logic             special_q;
	logic             pec_q;

	// drain
	logic [IW-1:0]    drain_len_q;
	logic [IW-1:0]    rd_q;

	// pending command event (second result after an overflow)
	logic [CMD_W-1:0] pend_cmd_q;
	logic [VAL_W-1:0] pend_val_q;
	logic             pend_pec_q;

	// line buffer
	logic [TAG_W+VAL_W-1:0] mem_q [LINE_DEPTH];
	logic [TAG_W+VAL_W-1:0] rdata_q;

	// output register
	logic             out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [TAG_W-1:0] out_tag_q;
	logic [VAL_W-1:0] out_val_q;
	logic [CMD_W-1:0] out_cmd_q;
	logic             out_pec_q;
	logic             out_last_q;

	// decode
	logic [7:0]       c_up;
	logic             is_dig;
	logic [3:0]       dig_val;
	logic             is_tag;
	logic [TAG_W-1:0] tag_code;
	logic             is_cmd;
	logic [CMD_W-1:0] cmd_code;
	logic             is_nl;
	logic             ovf;
	logic [IW-1:0]    idx_eff;
	logic             pec_new;
	logic             out_free;
	logic             start_drain;
	logic [7:0]       alpha_val;

	always_comb begin
		c_up = s_tdata;
		if (s_tdata >= CH_LOWER_A && s_tdata <= CH_LOWER_Z) begin
			c_up = s_tdata - CASE_OFFSET;
		end
	end

	assign alpha_val = c_up - ALPHA_BIAS;

	always_comb begin
		is_dig  = 1'b0;
		dig_val = '0;
		if (c_up >= CH_0 && c_up <= CH_9) begin
			is_dig  = 1'b1;
			dig_val = c_up[3:0];
		end else if (c_up >= CH_A && c_up <= CH_F) begin
			is_dig  = 1'b1;
			dig_val = alpha_val[3:0];
		end
	end

	always_comb begin
		is_tag   = 1'b1;
		tag_code = TAG_DATA;
		unique case (c_up)
			CH_DOLLAR: tag_code = TAG_DATA;
			CH_AT:     tag_code = TAG_ADDR;
			CH_W:      tag_code = TAG_WRITE;
			CH_R:      tag_code = TAG_READ;
			CH_HASH:   tag_code = TAG_COUNT;
			CH_AMP:    tag_code = TAG_BCOUNT;
			CH_P:      tag_code = TAG_PCALL;
			default:   is_tag   = 1'b0;
		endcase
	end

	always_comb begin
		is_cmd   = 1'b1;
		cmd_code = CMD_SCAN;
		unique case (c_up)
			CH_QUEST: cmd_code = CMD_SCAN;
			CH_BANG:  cmd_code = CMD_STATUS;
			CH_EQ:    cmd_code = CMD_PEC_SET;
			CH_I:     cmd_code = CMD_IDENTIFY;
			CH_S:     cmd_code = CMD_SPD100;
			CH_T:     cmd_code = CMD_SPD400;
			CH_V:     cmd_code = CMD_SPD10;
			CH_X:     cmd_code = CMD_BUS_RST;
			default:  is_cmd   = 1'b0;
		endcase
	end

	assign is_nl       = (c_up == CH_NL);
	assign ovf         = (idx_q >= LAST_IDX);
	assign idx_eff     = ovf ? '0 : idx_q;
	assign pec_new     = (cmd_code == CMD_PEC_SET) ? (acc_q != '0) : pec_q;
	assign out_free    = !out_valid_q || m_tready;
	assign start_drain = is_nl && !special_q && (idx_eff != '0);

	assign status.out_free    = out_free;
	assign status.ovf         = ovf;
	assign status.is_cmd      = is_cmd;
	assign status.start_drain = start_drain;
	assign status.rd_last     = ({1'b0, rd_q} + 1'b1) == {1'b0, drain_len_q};

	// line state and drain pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			idx_q       <= '0;
			special_q   <= 1'b0;
			pec_q       <= 1'b0;
			drain_len_q <= '0;
			rd_q        <= '0;
		end else begin
			if (cmd.accept) begin
				idx_q <= idx_eff;
				if (is_dig) begin
					acc_q <= {acc_q[3:0], dig_val};
				end else if (is_tag) begin
					idx_q <= idx_eff + 1'b1;
					acc_q <= '0;
				end else if (is_cmd) begin
					pec_q <= pec_new;
					if (cmd_code != CMD_BUS_RST) begin
						special_q <= 1'b1;
					end
				end else if (is_nl) begin
					acc_q     <= '0;
					idx_q     <= '0;
					special_q <= 1'b0;
					if (start_drain) begin
						drain_len_q <= idx_eff;
						rd_q        <= '0;
					end
				end
			end
			if (cmd.load_entry) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	// pending command payload
	always_ff @(posedge clk) begin
		if (cmd.accept && is_cmd) begin
			pend_cmd_q <= cmd_code;
			pend_val_q <= acc_q;
			pend_pec_q <= pec_new;
		end
	end

	// line buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.accept && !is_dig && is_tag) begin
			mem_q[idx_eff] <= {tag_code, acc_q};
		end
		rdata_q <= mem_q[rd_q];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_cmd || cmd.load_entry || cmd.load_stop ||
			    (cmd.accept && (ovf || is_cmd))) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.accept && ovf) begin
			// overflow goes out ahead of any update made by this byte
			out_kind_q <= KIND_OVERFLOW;
			out_tag_q  <= '0;
			out_val_q  <= '0;
			out_cmd_q  <= '0;
			out_pec_q  <= pec_q;
			out_last_q <= !is_cmd;
		end else if (cmd.accept && is_cmd) begin
			out_kind_q <= KIND_COMMAND;
			out_tag_q  <= '0;
			out_val_q  <= acc_q;
			out_cmd_q  <= cmd_code;
			out_pec_q  <= pec_new;
			out_last_q <= 1'b1;
		end else if (cmd.load_cmd) begin
			out_kind_q <= KIND_COMMAND;
			out_tag_q  <= '0;
			out_val_q  <= pend_val_q;
			out_cmd_q  <= pend_cmd_q;
			out_pec_q  <= pend_pec_q;
			out_last_q <= 1'b1;
		end else if (cmd.load_entry) begin
			out_kind_q <= KIND_ENTRY;
			out_tag_q  <= rdata_q[TAG_W+VAL_W-1:VAL_W];
			out_val_q  <= rdata_q[VAL_W-1:0];
			out_cmd_q  <= '0;
			out_pec_q  <= pec_q;
			out_last_q <= 1'b0;
		end else if (cmd.load_stop) begin
			out_kind_q <= KIND_ENTRY;
			out_tag_q  <= TAG_STOP;
			out_val_q  <= '0;
			out_cmd_q  <= '0;
			out_pec_q  <= pec_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_pec_q, out_cmd_q, out_val_q, out_tag_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("line index beyond buffer");

	a_stop_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_ENTRY && out_tag_q == TAG_STOP) |-> out_last_q)
		else $error("stop entry not marked last");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_cmd || cmd.load_entry || cmd.load_stop) |-> out_free)
		else $error("result loaded over an untaken one");
`endif

endmodule

>>> rtl/hex_command_line_tokenizer_core.sv
// Top level of the hex command line tokenizer: controller plus datapath.
`timescale 1ns / 1ps
// One ASCII byte per input transfer is folded to upper case and tokenized:
// hex digits shift into an 8-bit accumulator, tag characters ($ @ W R # & P)
// store a (tag, value) entry in the line buffer, command characters
// (? ! = I S T V X) produce a command event, and a newline sends out the
// buffered line entry by entry followed by a stop entry, unless the line held
// a command other than X (bus reset) or no entry. A line that fills
// LINE_DEPTH-1 entries produces an overflow event on the next byte and starts
// over. Each result is one output transfer; m_tlast marks the final result
// caused by an input byte. A byte is taken only in the idle state, when the
// output register is free or being emptied that cycle. A command byte on a
// full line yields its command event as a second result after the overflow
// event. A newline that sends entries holds off input; the line buffer read
// port is registered, so each entry takes a read state and an output state,
// then the stop entry follows. Downstream back-pressure stalls the output states.
module hex_command_line_tokenizer_core
	import hcl_pkg::*;
#(
	parameter int LINE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [2:0] tag, [10:3] value, [13:11] command, [14] pec_flag
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	hcl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	hcl_dp #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> dv/hcl_checker.sv
// Stream monitor for the hex command line tokenizer: predicts every result and compares it.
`timescale 1ns / 1ps
module hcl_checker
	import hcl_pkg::*;
#(
	parameter int LINE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [2:0] tag, [10:3] value, [13:11] command, [14] pec_flag
	input  logic [1:0]  m_tuser,   // [1:0] kind
	input  logic        m_tlast,
	output int          failures,
	output int          pending
);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TAG_W-1:0]  tag;
		logic [VAL_W-1:0]  value;
		logic [CMD_W-1:0]  command;
		logic              pec;
		logic              last;
	} token_result_t;

	// shadow of the tokenizer state
	logic [7:0]       hex_acc;
	logic [TAG_W-1:0] tag_mem [LINE_DEPTH];
	logic [VAL_W-1:0] val_mem [LINE_DEPTH];
	int               line_idx;
	logic             special_line;
	logic             pec_en;

	token_result_t    token_q[$];

	task automatic report_error(input string what, input int want_v, input int got_v);
		$display("ERROR %0t ns: %s: expected %0h, got %0h", $time, what, want_v, got_v);
		failures = failures + 1;
	endtask

	task automatic push_result(input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] tag,
		input logic [VAL_W-1:0] value, input logic [CMD_W-1:0] command);
		token_q.push_back('{kind, tag, value, command, pec_en, 1'b0});
	endtask

	// one received byte -> zero or more results appended to token_q
	task automatic tokenize_char(input logic [7:0] ch);
		logic [7:0]       c;
		logic [7:0]       nib;
		logic             is_tag;
		logic             is_cmd;
		logic [TAG_W-1:0] tg;
		logic [CMD_W-1:0] cmd;
		int               first;
		token_result_t    tail;

		first  = token_q.size();
		c      = ch;
		is_tag = 1'b0;
		is_cmd = 1'b0;
		tg     = TAG_DATA;
		cmd    = CMD_SCAN;

		// full buffer: overflow event, line dropped, byte still decoded
		if (line_idx >= LINE_DEPTH - 1) begin
			push_result(KIND_OVERFLOW, TAG_DATA, 8'd0, CMD_SCAN);
			line_idx = 0;
		end

		if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
			c = c - CASE_OFFSET;

		case (c)
			CH_DOLLAR: begin is_tag = 1'b1; tg = TAG_DATA;   end
			CH_AT:     begin is_tag = 1'b1; tg = TAG_ADDR;   end
			CH_W:      begin is_tag = 1'b1; tg = TAG_WRITE;  end
			CH_R:      begin is_tag = 1'b1; tg = TAG_READ;   end
			CH_HASH:   begin is_tag = 1'b1; tg = TAG_COUNT;  end
			CH_AMP:    begin is_tag = 1'b1; tg = TAG_BCOUNT; end
			CH_P:      begin is_tag = 1'b1; tg = TAG_PCALL;  end
			CH_QUEST:  begin is_cmd = 1'b1; cmd = CMD_SCAN;     end
			CH_BANG:   begin is_cmd = 1'b1; cmd = CMD_STATUS;   end
			CH_EQ:     begin is_cmd = 1'b1; cmd = CMD_PEC_SET;  end
			CH_I:      begin is_cmd = 1'b1; cmd = CMD_IDENTIFY; end
			CH_S:      begin is_cmd = 1'b1; cmd = CMD_SPD100;   end
			CH_T:      begin is_cmd = 1'b1; cmd = CMD_SPD400;   end
			CH_V:      begin is_cmd = 1'b1; cmd = CMD_SPD10;    end
			CH_X:      begin is_cmd = 1'b1; cmd = CMD_BUS_RST;  end
			default: ;
		endcase

		if (c >= CH_0 && c <= CH_9) begin
			nib     = c - CH_0;
			hex_acc = {hex_acc[3:0], nib[3:0]};
		end else if (c >= CH_A && c <= CH_F) begin
			nib     = c - ALPHA_BIAS;
			hex_acc = {hex_acc[3:0], nib[3:0]};
		end else if (is_tag) begin
			if (line_idx < LINE_DEPTH) begin
				tag_mem[line_idx] = tg;
				val_mem[line_idx] = hex_acc;
				line_idx = line_idx + 1;
			end
			hex_acc = 8'd0;
		end else if (is_cmd) begin
			if (cmd == CMD_PEC_SET)
				pec_en = (hex_acc != 8'd0);
			// bus reset leaves the line sendable
			if (cmd != CMD_BUS_RST)
				special_line = 1'b1;
			push_result(KIND_COMMAND, TAG_DATA, hex_acc, cmd);
		end else if (c == CH_NL) begin
			if (!special_line && line_idx > 0) begin
				for (int i = 0; i < line_idx; i++)
					push_result(KIND_ENTRY, tag_mem[i], val_mem[i], CMD_SCAN);
				push_result(KIND_ENTRY, TAG_STOP, 8'd0, CMD_SCAN);
			end
			hex_acc      = 8'd0;
			line_idx     = 0;
			special_line = 1'b0;
		end

		// tlast goes on the final result of this byte
		if (token_q.size() > first) begin
			tail      = token_q.pop_back();
			tail.last = 1'b1;
			token_q.push_back(tail);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_result_t want;
		if (!arst_n) begin
			hex_acc      = 8'd0;
			line_idx     = 0;
			special_line = 1'b0;
			pec_en       = 1'b0;
			token_q.delete();
		end else begin
			// a result leaving now always belongs to an earlier byte
			if (m_tvalid && m_tready) begin
				if (token_q.size() == 0) begin
					report_error("result transfer with none outstanding", 0, {m_tuser, m_tdata});
				end else begin
					want = token_q.pop_front();
					if (m_tuser != want.kind)
						report_error("kind", want.kind, m_tuser);
					if (m_tdata[2:0] != want.tag)
						report_error("tag", want.tag, m_tdata[2:0]);
					if (m_tdata[10:3] != want.value)
						report_error("value", want.value, m_tdata[10:3]);
					if (m_tdata[13:11] != want.command)
						report_error("command", want.command, m_tdata[13:11]);
					if (m_tdata[14] != want.pec)
						report_error("pec_flag", want.pec, m_tdata[14]);
					if (m_tlast != want.last)
						report_error("tlast", want.last, m_tlast);
				end
			end
			if (s_tvalid && s_tready)
				tokenize_char(s_tdata);
		end
		pending <= token_q.size();
	end

endmodule

>>> dv/tb_top.sv
// Testbench top for the hex command line tokenizer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import hcl_pkg::*;

	localparam int LINE_DEPTH  = 32;
	localparam int HOLD_CYCLES = 300;     // long downstream hold-off in the first random phase
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 100;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;   // [7:0] char_in
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // [2:0] tag, [10:3] value, [13:11] command, [14] pec_flag
	logic [1:0]  m_tuser;           // [1:0] kind
	logic        m_tlast;

	int   failures;
	int   pending;
	int   tx_idle_pct  = 0;
	int   rx_stall_pct = 0;
	int   sent_cnt     = 0;
	int   cycle_cnt    = 0;
	logic hold_go      = 1'b0;
	logic hold_done    = 1'b0;
	int   hold_cnt     = 0;

	always #4 clk = ~clk;

	hex_command_line_tokenizer_core #(
		.LINE_DEPTH(LINE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	hcl_checker #(
		.LINE_DEPTH(LINE_DEPTH)
	) i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.failures (failures),
		.pending  (pending)
	);

	// downstream side: random stalls, plus one long hold-off so the block backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_go && !hold_done) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("hex_command_line_tokenizer_core: mismatch");
			$finish;
		end
	end

	// one byte, with random upstream gaps in front of it
	task automatic send_char(input logic [7:0] c, input bit counted);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		do
			@(posedge clk);
		while (!s_tready);
		if (counted)
			sent_cnt = sent_cnt + 1;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b1);
	endtask

	// letters come out in either case; the block folds them
	function automatic logic [7:0] any_case(input logic [7:0] c);
		if (c >= CH_A && c <= CH_X && $urandom_range(1))
			return c + CASE_OFFSET;
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input int v);
		if (v < 10)
			return 8'(CH_0 + v);
		return any_case(8'(CH_A + v - 10));
	endfunction

	function automatic logic [7:0] tag_char();
		case ($urandom_range(6))
			0: return CH_DOLLAR;
			1: return CH_AT;
			2: return any_case(CH_W);
			3: return any_case(CH_R);
			4: return CH_HASH;
			5: return CH_AMP;
			default: return any_case(CH_P);
		endcase
	endfunction

	function automatic logic [7:0] cmd_char();
		case ($urandom_range(7))
			0: return CH_QUEST;
			1: return CH_BANG;
			2: return CH_EQ;
			3: return any_case(CH_I);
			4: return any_case(CH_S);
			5: return any_case(CH_T);
			6: return any_case(CH_V);
			default: return any_case(CH_X);
		endcase
	endfunction

	// a command line: entries of hex digits plus a tag, usually closed by a newline.
	// Long lines can run past the buffer and trip the overflow event.
	task automatic send_line(input bit long_line);
		int n_ent;
		int n_dig;
		n_ent = long_line ? $urandom_range(29, 36) : $urandom_range(0, 6);
		for (int e = 0; e < n_ent; e++) begin
			n_dig = long_line ? $urandom_range(0, 1) : $urandom_range(0, 3);
			for (int d = 0; d < n_dig; d++)
				send_char(hex_char($urandom_range(15)), 1'b1);
			if ($urandom_range(19) == 0)
				send_char(cmd_char(), 1'b1);
			send_char(tag_char(), 1'b1);
		end
		if (long_line && $urandom_range(1))
			send_char(cmd_char(), 1'b1);
		if ($urandom_range(9) != 0)
			send_char(CH_NL, 1'b1);
	endtask

	initial begin
		int line_no;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: digit wrap, hex letters in both cases, every tag but @, ignored extremes, a line sent
		send_text("123$Ffwr#&p");
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		// pec set on, every command, special line and empty line dropped, pec set off
		send_text("\n5=?!istvx\n\n=");

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
				default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
			endcase
			if (phase == 0)
				hold_go <= 1'b1;
			sent_cnt = 0;
			line_no  = 0;
			while (sent_cnt < PHASE_ITEMS) begin
				if ($urandom_range(7) == 0)
					send_char(8'($urandom_range(255)), 1'b0);
				else
					send_line(line_no % 5 == 2);
				line_no++;
			end
		end
		s_tvalid <= 1'b0;

		// the count of outstanding results is registered, so it trails the last transfer
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2 * LINE_DEPTH + 8) @(posedge clk);

		if (failures == 0)
			$display("hex_command_line_tokenizer_core: match");
		else
			$display("hex_command_line_tokenizer_core: mismatch");
		$finish;
	end

endmodule

>>> hex_command_line_tokenizer_core.f
rtl/hcl_pkg.sv
rtl/hcl_ctrl.sv
rtl/hcl_dp.sv
rtl/hex_command_line_tokenizer_core.sv
dv/hcl_checker.sv
dv/tb_top.sv
